FILE: hw/rtl/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg
// shared widths, cell operation codes and chain control/status types
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int POS_W           = 16;
    localparam int SEEK_W          = 18;
    localparam int MAX_REQUESTS_DEF = 32;
    localparam logic [POS_W-1:0] CYL_END_RST = 16'hFFFF;

    typedef logic [1:0] t_cell_op;

    localparam t_cell_op OP_HOLD   = 2'd0;
    localparam t_cell_op OP_INSERT = 2'd1;  // sorted insert, ascending from cell 0
    localparam t_cell_op OP_PUSH   = 2'd2;  // shift away from cell 0, new value at cell 0
    localparam t_cell_op OP_POP    = 2'd3;  // shift toward cell 0, cell 0 leaves

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] din;
    } t_chain_ctl;

    typedef struct packed {
        logic [POS_W-1:0] head_val;
        logic             head_vld;
        logic             next_vld;
    } t_chain_sts;

endpackage

FILE: hw/rtl/scan_disk_scheduler.sv
`timescale 1ns / 1ps
// load beat: sorted into the request chain in place
// run beat: each request at or below the head goes onto the stack, then the
//   sequencer turns and gives n + 2 result beats, one per cycle unless stalled
// input stalls from run accept until the last result beat is registered
// reset (synchronous, active low) empties both chains, clears the request
//   count and sets cylinder_end to 65535
// ----------------------------------------------------------------------------
// scan_disk_scheduler
// SCAN elevator scheduler: sorted request chain, reversal stack and sequencer
// ----------------------------------------------------------------------------
module scan_disk_scheduler
    import sds_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [POS_W-1:0]  i_cylinder,
    input  logic              i_move_up,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [POS_W-1:0]  o_position,
    output logic [SEEK_W-1:0] o_seek_total,
    output logic              o_last,
    // cylinder_end write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [POS_W-1:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // taking load and run beats
    localparam logic [2:0] S_XFER  = 3'd1;  // lower side goes onto the stack
    localparam logic [2:0] S_HEAD  = 3'd2;  // start head result
    localparam logic [2:0] S_SIDE1 = 3'd3;  // travel side, then the boundary
    localparam logic [2:0] S_SIDE2 = 3'd4;  // far side after the turn

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_cyl_end;
    logic [POS_W-1:0]  r_head, n_head;      // current head position
    logic [SEEK_W-1:0] r_seek, n_seek;
    logic              r_up;

    logic              r_out_vld, n_out_vld;
    logic [POS_W-1:0]  r_out_pos;
    logic [SEEK_W-1:0] r_out_seek;
    logic              r_out_last;

    t_chain_ctl main_ctl, stk_ctl;
    t_chain_sts main_sts, stk_sts;
    t_chain_sts side1_sts, side2_sts;

    logic              in_acc;
    logic              out_free;
    logic              emit_en;
    logic [POS_W-1:0]  emit_pos;
    logic              emit_last;
    logic [POS_W-1:0]  step_len;
    logic [POS_W-1:0]  clamped;
    logic [POS_W-1:0]  bound;
    logic              xfer_go;

    // ------------------------------------------------------------------
    // request chain holds pending requests in ascending order, the stack
    // chain takes the lower side so it comes back out descending
    // ------------------------------------------------------------------
    sds_chain #(.DEPTH(MAX_REQUESTS)) u_main (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (main_ctl),
        .o_sts   (main_sts)
    );

    sds_chain #(.DEPTH(MAX_REQUESTS)) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_sts   (stk_sts)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_vld || !i_stall;

    // requests beyond the boundary in force at load time are clamped
    assign clamped = (i_cylinder > r_cyl_end) ? r_cyl_end : i_cylinder;

    // moving up: requests above the head first, stack after the turn
    // moving down: stack first, then the requests above the head
    assign side1_sts = r_up ? main_sts : stk_sts;
    assign side2_sts = r_up ? stk_sts : main_sts;
    assign bound     = r_up ? r_cyl_end : '0;

    assign xfer_go = main_sts.head_vld && (main_sts.head_val <= r_head);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        main_ctl.op  = OP_HOLD;
        main_ctl.din = clamped;
        stk_ctl.op   = OP_HOLD;
        stk_ctl.din  = main_sts.head_val;
        emit_en      = 1'b0;
        emit_pos     = r_head;
        emit_last    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type) begin
                        n_state = S_XFER;
                    end else if (r_count < CNT_W'(MAX_REQUESTS)) begin
                        // room left: insert; a load beat to a full store is dropped
                        main_ctl.op = OP_INSERT;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
            end
            S_XFER: begin
                if (xfer_go) begin
                    main_ctl.op = OP_POP;
                    stk_ctl.op  = OP_PUSH;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (out_free) begin
                    emit_en  = 1'b1;
                    emit_pos = r_head;
                    n_state  = S_SIDE1;
                end
            end
            S_SIDE1: begin
                if (out_free) begin
                    emit_en = 1'b1;
                    if (side1_sts.head_vld) begin
                        emit_pos = side1_sts.head_val;
                        if (r_up) begin
                            main_ctl.op = OP_POP;
                        end else begin
                            stk_ctl.op = OP_POP;
                        end
                    end else begin
                        // turn at the boundary, last when nothing lies behind
                        emit_pos  = bound;
                        emit_last = !side2_sts.head_vld;
                        n_state   = side2_sts.head_vld ? S_SIDE2 : S_IDLE;
                    end
                end
            end
            S_SIDE2: begin
                if (out_free) begin
                    emit_en   = 1'b1;
                    emit_pos  = side2_sts.head_val;
                    emit_last = !side2_sts.next_vld;
                    if (r_up) begin
                        stk_ctl.op = OP_POP;
                    end else begin
                        main_ctl.op = OP_POP;
                    end
                    if (!side2_sts.next_vld) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // store is empty once the sweep has ended
        if (emit_en && emit_last) begin
            n_count = '0;
        end
    end

    // head movement for the result being issued
    assign step_len = (emit_pos > r_head) ? (emit_pos - r_head) : (r_head - emit_pos);

    always_comb begin
        n_head = r_head;
        n_seek = r_seek;
        if (in_acc && i_req_type) begin
            n_head = i_cylinder;
            n_seek = '0;
        end else if (emit_en) begin
            n_head = emit_pos;
            n_seek = r_seek + SEEK_W'(step_len);
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (emit_en) begin
            n_out_vld = 1'b1;
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cyl_end <= CYL_END_RST;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cyl_end <= i_cfg_data;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_seek <= n_seek;
        if (in_acc && i_req_type) begin
            r_up <= i_move_up;
        end
        if (emit_en) begin
            r_out_pos  <= emit_pos;
            r_out_seek <= n_seek;
            r_out_last <= emit_last;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_position   = r_out_pos;
    assign o_seek_total = r_out_seek;
    assign o_last       = r_out_last;

`ifndef SYNTHESIS
    // no request may be left on the stack once a sweep is over
    a_stack_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !stk_sts.head_vld)
        else $error("stack chain not empty while idle");

    // request count and chain occupancy agree between runs
    a_count_matches_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (main_sts.head_vld == (r_count != '0)))
        else $error("request count disagrees with chain contents");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REQUESTS))
        else $error("request count above capacity");

    // a last beat always returns the sequencer to idle
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_en && emit_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after last beat");
`endif

endmodule

FILE: hw/rtl/sds_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_cell
// one slot of a request chain: value plus valid, talks to both neighbours
// ----------------------------------------------------------------------------
module sds_cell
    import sds_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chain_ctl       i_ctl,
    input  logic [POS_W-1:0] i_lo_val,
    input  logic             i_lo_vld,
    input  logic             i_lo_lt,
    input  logic [POS_W-1:0] i_up_val,
    input  logic             i_up_vld,
    output logic [POS_W-1:0] o_val,
    output logic             o_vld,
    output logic             o_lt
);

    logic [POS_W-1:0] r_val, n_val;
    logic             r_vld, n_vld;

    // empty slots count as larger than anything
    assign o_lt  = !r_vld || (i_ctl.din < r_val);
    assign o_val = r_val;
    assign o_vld = r_vld;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (o_lt) begin
                    if (i_lo_lt) begin
                        n_val = i_lo_val;
                        n_vld = i_lo_vld;
                    end else begin
                        n_val = i_ctl.din;
                        n_vld = 1'b1;
                    end
                end
            end
            OP_PUSH: begin
                n_val = i_lo_val;
                n_vld = i_lo_vld;
            end
            OP_POP: begin
                n_val = i_up_val;
                n_vld = i_up_vld;
            end
            default: begin
                n_val = r_val;
                n_vld = r_vld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: hw/rtl/sds_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_chain
// row of cells, sorted store or stack depending on the ops applied
// ----------------------------------------------------------------------------
module sds_chain
    import sds_pkg::*;
#(
    parameter int DEPTH = MAX_REQUESTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain_ctl i_ctl,
    output t_chain_sts o_sts
);

    logic [POS_W-1:0] w_val [DEPTH];
    logic             w_vld [DEPTH];
    logic             w_lt  [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [POS_W-1:0] lo_val, up_val;
            logic             lo_vld, lo_lt, up_vld;

            if (g == 0) begin : g_lo_end
                // cell 0 sees the incoming value as its lower neighbour
                assign lo_val = i_ctl.din;
                assign lo_vld = 1'b1;
                assign lo_lt  = 1'b0;
            end else begin : g_lo_nb
                assign lo_val = w_val[g-1];
                assign lo_vld = w_vld[g-1];
                assign lo_lt  = w_lt[g-1];
            end

            if (g == DEPTH - 1) begin : g_up_end
                assign up_val = '0;
                assign up_vld = 1'b0;
            end else begin : g_up_nb
                assign up_val = w_val[g+1];
                assign up_vld = w_vld[g+1];
            end

            sds_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (i_ctl),
                .i_lo_val (lo_val),
                .i_lo_vld (lo_vld),
                .i_lo_lt  (lo_lt),
                .i_up_val (up_val),
                .i_up_vld (up_vld),
                .o_val    (w_val[g]),
                .o_vld    (w_vld[g]),
                .o_lt     (w_lt[g])
            );
        end

        if (DEPTH > 1) begin : g_next
            assign o_sts.next_vld = w_vld[1];
        end else begin : g_no_next
            assign o_sts.next_vld = 1'b0;
        end
    endgenerate

    assign o_sts.head_val = w_val[0];
    assign o_sts.head_vld = w_vld[0];

endmodule
